// ----- src/pse_pkg.sv -----
// Shared types and constants for the postfix stack evaluator.
// Holds the token command codes and the controller-to-datapath command and status bundles.
// No dependencies.
package pse_pkg;

    localparam int DATA_W    = 32;
    localparam int VAL_W     = 31;
    localparam int CMD_W     = 3;
    localparam int IN_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_MOD     = 3'd5,
        CMD_UNKNOWN = 3'd6
    } cmd_t;

    typedef struct packed {
        logic push;
        logic read_lhs;
        logic alu_wr;
        logic div_start;
        logic div_wr;
        logic emit;
        logic emit_err;
        cmd_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic count_full;
        logic count_lt2;
        logic rhs_zero;
        logic div_done;
        logic out_busy;
    } dp_stat_t;

endpackage

// ----- src/postfix_stack_evaluator_unit.sv -----
// Postfix stack evaluator: one token per input beat, one result beat per expression.
// A push writes the stack when accepted; add, subtract, multiply and unknown read the stack,
// then use the ALU; divide and modulo read the stack, then wait for the radix-2 divider.
// After a last token the emit state loads the output register, which then holds the result beat.
// Reset clears the controller, stack count and output valid; stack memory is not cleared.
module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pse_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // command, operand_value, zero pad
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pse_pkg::DATA_W-1:0]     m_axis_tdata,  // result_value
    output logic                           m_axis_tuser   // status
);
    import pse_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (cmd_t'(s_axis_tdata[CMD_W-1:0])),
        .in_last  (s_axis_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .push_value (s_axis_tdata[CMD_W+VAL_W-1:CMD_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

endmodule

// ----- src/pse_div.sv -----
// Radix-2 restoring divider for signed 32-bit quotient and remainder.
// One quotient bit per cycle on magnitudes, signs fixed up at the output.
// Depends on pse_pkg.
module pse_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       is_mod,
    input  logic [pse_pkg::DATA_W-1:0] dividend,
    input  logic [pse_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [pse_pkg::DATA_W-1:0] result
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic              qneg_reg;
    logic              rneg_reg;
    logic              mod_reg;

    logic [DATA_W-1:0] a_abs;
    logic [DATA_W-1:0] b_abs;
    logic [DATA_W:0]   trial;

    assign a_abs = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign b_abs = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= a_abs;
            rem_reg  <= '0;
            den_reg  <= b_abs;
            qneg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rneg_reg <= dividend[DATA_W-1];
            mod_reg  <= is_mod;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (mod_reg)
            result = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;
        else
            result = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    end

    assign done = done_reg;

endmodule

// ----- src/pse_datapath.sv -----
// Datapath of the postfix stack evaluator: operand stack memory, top-of-stack register,
// ALU, shared divider and the output register.
// Depends on pse_pkg and pse_div.
module pse_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pse_pkg::dp_cmd_t           cmd,
    output pse_pkg::dp_stat_t          stat,
    input  logic [pse_pkg::VAL_W-1:0]  push_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [pse_pkg::DATA_W-1:0] out_data,
    output logic                       out_status
);
    import pse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic [DATA_W-1:0] rd_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_status_reg;

    logic [AW-1:0]     wr_ptr;
    logic [AW-1:0]     rd_ptr;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] div_res;
    logic              div_done;
    logic              invalid;

    assign wr_ptr = AW'(count_reg - 1'b1);
    assign rd_ptr = AW'(count_reg - CW'(2));

    always_comb
    begin
        case (cmd.op)
            CMD_ADD: alu_res = rd_reg + tos_reg;
            CMD_SUB: alu_res = rd_reg - tos_reg;
            CMD_MUL: alu_res = rd_reg * tos_reg;
            default: alu_res = '0;
        endcase
    end

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .is_mod   (cmd.op == CMD_MOD),
        .dividend (rd_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .result   (div_res)
    );

    always_comb
    begin
        count_next = count_reg;
        tos_next   = tos_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
            tos_next   = {1'b0, push_value};
        end
        else if (cmd.alu_wr)
        begin
            count_next = count_reg - 1'b1;
            tos_next   = alu_res;
        end
        else if (cmd.div_wr)
        begin
            count_next = count_reg - 1'b1;
            tos_next   = div_res;
        end
        else if (cmd.emit)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign invalid = cmd.emit_err || (count_reg == '0);

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (cmd.emit)
        begin
            out_data_reg   <= invalid ? '0 : tos_reg;
            out_status_reg <= invalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && (count_reg != '0))
            mem[wr_ptr] <= tos_reg;
        if (cmd.read_lhs)
            rd_reg <= mem[rd_ptr];
    end

    assign stat.count_full = (count_reg >= CW'(STACK_DEPTH));
    assign stat.count_lt2  = (count_reg < CW'(2));
    assign stat.rhs_zero   = (tos_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

// ----- src/pse_ctrl.sv -----
// Controller of the postfix stack evaluator: token sequencing, error tracking and
// result emission. Drives the datapath through command and status bundles.
// Depends on pse_pkg.
module pse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pse_pkg::cmd_t     in_cmd,
    input  logic              in_last,
    output pse_pkg::dp_cmd_t  cmd,
    input  pse_pkg::dp_stat_t stat
);
    import pse_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OPER,
        ST_DIVW,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   err_reg, err_next;
    cmd_t   op_reg, op_next;
    logic   last_reg, last_next;
    logic   tok_done;

    always_comb
    begin
        state_next   = state_reg;
        err_next     = err_reg;
        op_next      = op_reg;
        last_next    = last_reg;
        tok_done     = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.emit_err = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_cmd;
                    last_next = in_last;
                    tok_done  = 1'b1;
                    if (!err_reg)
                    begin
                        if (in_cmd == CMD_PUSH)
                        begin
                            if (stat.count_full)
                                err_next = 1'b1;
                            else
                                cmd.push = 1'b1;
                        end
                        else if (stat.count_lt2)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cmd.read_lhs = 1'b1;
                            tok_done     = 1'b0;
                            state_next   = ST_OPER;
                        end
                    end
                    if (tok_done)
                        state_next = in_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_OPER:
            begin
                if ((op_reg == CMD_DIV) || (op_reg == CMD_MOD))
                begin
                    if (stat.rhs_zero)
                    begin
                        err_next   = 1'b1;
                        state_next = last_reg ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVW;
                    end
                end
                else
                begin
                    cmd.alu_wr = 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    cmd.div_wr = 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    err_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= 1'b0;
            op_reg    <= CMD_PUSH;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            op_reg    <= op_next;
            last_reg  <= last_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ----- src/pse_checker.sv -----
// Port-level checker for the postfix stack evaluator and its bind to the top level.
// Depends on pse_pkg.
module pse_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [pse_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pse_pkg::DATA_W-1:0]     m_axis_tdata,
    input logic                           m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled result beat changed.");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("Invalid result carries a nonzero value.");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("Input accepted while a result was being emitted.");

    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("Result beat appeared without an emit cycle.");

    a_no_data_unused: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("Result beat produced by a token that was not last.");

endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (.*);

// ----- test/postfix_stack_evaluator_unit_tb.sv -----
// Self-checking testbench for the postfix stack evaluator unit.
// Drives input token beats; checks result beats against an internal predictor or directed rows.
// Depends on pse_pkg and postfix_stack_evaluator_unit.
`timescale 1ns / 1ps

module postfix_stack_evaluator_unit_tb;

    import pse_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int RANDOM_TOKENS = 550;
    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] val;
        bit               is_last;
        bit               typed;
        logic [DATA_W-1:0] exp_value;
        bit               exp_status;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              status;
    } eval_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;

    logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
    int unsigned       eval_depth;
    bit                eval_error;

    eval_result_t expected_results[$];
    token_t       directed_tokens[$];
    token_t       expr_tokens[$];

    bit steady = 1'b0;
    int failures = 0;
    int live_tokens = 0;
    int token_beats = 0;
    int result_beats = 0;
    int invalid_beats = 0;

    postfix_stack_evaluator_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic evaluate_token(input token_t t, output bit has_result,
                                  output eval_result_t r);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        bit                ok;
        has_result = 1'b0;
        r = '0;
        if (!eval_error)
        begin
            live_tokens++;
            if (t.cmd == CMD_PUSH)
            begin
                if (eval_depth >= STACK_DEPTH)
                    eval_error = 1'b1;
                else
                begin
                    eval_stack[eval_depth] = {1'b0, t.val};
                    eval_depth++;
                end
            end
            else if (eval_depth < 2)
                eval_error = 1'b1;
            else
            begin
                rhs = eval_stack[eval_depth - 1];
                lhs = eval_stack[eval_depth - 2];
                ok = 1'b1;
                res = '0;
                case (t.cmd)
                    CMD_ADD: res = lhs + rhs;
                    CMD_SUB: res = lhs - rhs;
                    CMD_MUL: res = lhs * rhs;
                    CMD_DIV, CMD_MOD:
                    begin
                        if (rhs == '0)
                            ok = 1'b0;
                        else if (rhs == '1)
                            res = (t.cmd == CMD_DIV) ? 32'd0 - lhs : 32'd0;
                        else if (t.cmd == CMD_DIV)
                            res = $signed(lhs) / $signed(rhs);
                        else
                            res = $signed(lhs) % $signed(rhs);
                    end
                    default: res = '0;
                endcase
                if (!ok)
                    eval_error = 1'b1;
                else
                begin
                    eval_depth--;
                    eval_stack[eval_depth - 1] = res;
                end
            end
        end
        if (t.is_last)
        begin
            has_result = 1'b1;
            if (eval_error || eval_depth == 0)
                r = '{value: '0, status: 1'b1};
            else
                r = '{value: eval_stack[eval_depth - 1], status: 1'b0};
            eval_depth = 0;
            eval_error = 1'b0;
        end
    endtask

    task automatic send_token(input token_t t);
        bit           has_result;
        eval_result_t r;
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W - VAL_W - CMD_W){1'b0}}, t.val, t.cmd};
        s_axis_tlast <= t.is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        token_beats++;
        evaluate_token(t, has_result, r);
        if (has_result)
        begin
            if (t.typed)
                expected_results.insert(expected_results.size(),
                                        '{value: t.exp_value, status: t.exp_status});
            else
                expected_results.insert(expected_results.size(), r);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                           input bit is_last, input bit typed,
                           input logic [DATA_W-1:0] exp_value, input bit exp_status);
        token_t t;
        t = '{cmd: cmd, val: val, is_last: is_last, typed: typed,
              exp_value: exp_value, exp_status: exp_status};
        directed_tokens.insert(directed_tokens.size(), t);
    endtask

    task automatic push_expr(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
        token_t t;
        t = '{cmd: cmd, val: val, is_last: 1'b0, typed: 1'b0, exp_value: '0, exp_status: 1'b0};
        expr_tokens.insert(expr_tokens.size(), t);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return VAL_W'($urandom_range(0, 9));
        else if (r < 35)
            return (r < 29) ? VAL_MAX : ((r < 32) ? 31'd0 : 31'd1);
        else if (r < 50)
            return VAL_W'($urandom_range(0, 1000));
        else
            return VAL_W'($urandom() & VAL_MAX);
    endfunction

    function automatic logic [CMD_W-1:0] pick_operator();
        int r;
        r = $urandom_range(0, 99);
        if (r < 94)
            return CMD_W'($urandom_range(CMD_ADD, CMD_MOD));
        else if (r < 98)
            return CMD_UNKNOWN;
        else
            return CMD_SPARE;
    endfunction

    task automatic add_leaf();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6 || r >= 12 && r < 15)
        begin
            push_expr(CMD_PUSH, 31'h4000_0000);
            push_expr(CMD_PUSH, 31'd2);
            push_expr(CMD_MUL, '0);
        end
        if (r >= 6 && r < 15)
        begin
            push_expr(CMD_PUSH, 31'd0);
            push_expr(CMD_PUSH, 31'd1);
            push_expr(CMD_SUB, '0);
        end
        if (r >= 12 && r < 15)
            push_expr($urandom_range(0, 1) ? CMD_DIV : CMD_MOD, '0);
        else if (r >= 15)
            push_expr(CMD_PUSH, pick_value());
    endtask

    task automatic build_expression();
        int kind;
        int n;
        int depth;
        int placed;
        int leaves;
        int keep;
        token_t t;
        expr_tokens.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                push_expr(CMD_W'($urandom_range(0, 7)), VAL_W'($urandom() & VAL_MAX));
        end
        else if (kind < 11)
        begin
            n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
            repeat (n)
                push_expr(CMD_PUSH, pick_value());
            n = $urandom_range(0, 3);
            repeat (n)
                push_expr(pick_operator(), '0);
        end
        else
        begin
            leaves = $urandom_range(1, 8);
            keep = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : 1;
            depth = 0;
            placed = 0;
            while (placed < leaves || depth > keep)
            begin
                if (placed < leaves && (depth < 2 || $urandom_range(0, 1)))
                begin
                    add_leaf();
                    placed++;
                    depth++;
                end
                else
                begin
                    push_expr(pick_operator(), '0);
                    depth--;
                end
            end
            if (kind < 15)
            begin
                t = '{cmd: pick_operator(), val: '0, is_last: 1'b0, typed: 1'b0,
                      exp_value: '0, exp_status: 1'b0};
                if ($urandom_range(0, 1))
                    expr_tokens.push_front(t);
                else
                    expr_tokens.insert(expr_tokens.size(), t);
            end
        end
        expr_tokens[expr_tokens.size() - 1].is_last = 1'b1;
    endtask

    always @(posedge clk)
    begin
        eval_result_t exp_r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_beats++;
                if (m_axis_tuser)
                    invalid_beats++;
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("Unexpected result beat: value %h status %b",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_axis_tdata !== exp_r.value || m_axis_tuser !== exp_r.status)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("Mismatch on result %0d: expected %h/%b, got %h/%b",
                                     result_beats, exp_r.value, exp_r.status,
                                     m_axis_tdata, m_axis_tuser);
                    end
                end
            end
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
        end
    end

    initial
    begin
        int random_base;
        bit pressed;

        add_row(CMD_PUSH, VAL_MAX, 1, 1, 32'h7FFF_FFFF, 0);
        add_row(CMD_ADD, 31'd0, 1, 1, 32'd0, 1);
        add_row(CMD_PUSH, 31'd3, 0, 0, 32'd0, 0);
        add_row(CMD_MUL, 31'd0, 1, 1, 32'd0, 1);
        add_row(CMD_PUSH, VAL_MAX, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, VAL_MAX, 0, 0, 32'd0, 0);
        add_row(CMD_MUL, 31'd0, 1, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd7, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd0, 0, 0, 32'd0, 0);
        add_row(CMD_DIV, 31'd0, 1, 1, 32'd0, 1);
        add_row(CMD_PUSH, 31'd7, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd0, 0, 0, 32'd0, 0);
        add_row(CMD_MOD, 31'd0, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd1, 1, 1, 32'd0, 1);
        add_row(CMD_PUSH, 31'h4000_0000, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd2, 0, 0, 32'd0, 0);
        add_row(CMD_MUL, 31'd0, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd0, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd1, 0, 0, 32'd0, 0);
        add_row(CMD_SUB, 31'd0, 0, 0, 32'd0, 0);
        add_row(CMD_DIV, 31'd0, 1, 1, INT_MIN, 0);
        add_row(CMD_PUSH, 31'd13, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd4, 0, 0, 32'd0, 0);
        add_row(CMD_UNKNOWN, VAL_MAX, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd9, 0, 0, 32'd0, 0);
        add_row(CMD_SPARE, 31'd0, 0, 0, 32'd0, 0);
        add_row(CMD_PUSH, 31'd6, 1, 0, 32'd0, 0);

        eval_depth = 0;
        eval_error = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tokens[i])
            send_token(directed_tokens[i]);
        drain_results();

        random_base = live_tokens;
        pressed = 1'b0;
        while (live_tokens < random_base + RANDOM_TOKENS)
        begin
            steady = (live_tokens >= random_base + 200) && (live_tokens < random_base + 320);
            if (!pressed && live_tokens >= random_base + 400)
            begin
                drain_results();
                pressed = 1'b1;
            end
            build_expression();
            foreach (expr_tokens[i])
                send_token(expr_tokens[i]);
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);

        $display("Sent %0d token beats and checked %0d result beats, %0d of them invalid.",
                 token_beats, result_beats, invalid_beats);
        $display("Covered all operators, zero divisors, overflow, too few operands and wrap.");
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/pse_pkg.sv
src/pse_div.sv
src/pse_datapath.sv
src/pse_ctrl.sv
src/postfix_stack_evaluator_unit.sv
src/pse_checker.sv
test/postfix_stack_evaluator_unit_tb.sv
